// ===== rtl/ftb_pkg.sv =====
// ftb_pkg: shared types and constants for the per-flow token bucket policer.
// Used by ftb_ctrl, ftb_datapath, the top level and the checker.
package ftb_pkg;

   localparam int FLOWS_DEFAULT    = 1024;
   localparam int FLOW_W           = 10;
   localparam int TIME_W           = 64;
   localparam int LEVEL_W          = 30;
   localparam int CSR_W            = 20;
   localparam int CSR_IDX_W        = 1;
   localparam int ELAPSED_W        = 33;
   localparam int PROD_W           = ELAPSED_W + CSR_W;
   localparam int SUM_W            = PROD_W + 1;
   localparam int MILLI_W          = 10;

   localparam logic [MILLI_W-1:0]   MILLI_PER_PACKET = MILLI_W'(1000);
   localparam logic [CSR_W-1:0]     RATE_RESET       = CSR_W'(1000);
   localparam logic [CSR_W-1:0]     BURST_RESET      = CSR_W'(2000);
   localparam logic [LEVEL_W-1:0]   CAP_RESET        = LEVEL_W'(2000000);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = {1'b1, 32'h0};

   localparam logic [CSR_IDX_W-1:0] CSR_RATE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MULT,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic lookup;
      logic mult;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } dp_status_type;

   typedef struct packed {
      logic               primed;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  last_ms;
   } entry_type;

endpackage

// ===== rtl/ftb_ctrl.sv =====
// ftb_ctrl: sequencer for the policer (clear pass, accept, lookup, multiply, update).
// Depends on ftb_pkg; drives ftb_datapath through dp_cmd_type.
module ftb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ftb_pkg::dp_status_type status,
   output ftb_pkg::dp_cmd_type    cmd
);
   import ftb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_MULT;
         ST_MULT:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR:  cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_MULT:   cmd.mult   = 1'b1;
         ST_UPDATE: cmd.commit = status.slot_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ===== rtl/ftb_datapath.sv =====
// ftb_datapath: flow table memory, config registers, refill arithmetic, result register.
// Depends on ftb_pkg; sequenced by ftb_ctrl.
module ftb_datapath #(
   parameter int FLOWS = ftb_pkg::FLOWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ftb_pkg::dp_cmd_type             cmd,
   output ftb_pkg::dp_status_type          status,
   input  logic                            csr_write,
   input  logic [ftb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ftb_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [ftb_pkg::FLOW_W-1:0]      req_flow_index,
   input  logic [ftb_pkg::TIME_W-1:0]      req_now_ms,
   input  logic                            req_new_flow,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_allow,
   output logic [ftb_pkg::LEVEL_W-1:0]     rsp_level_left
);
   import ftb_pkg::*;

   localparam int ADDR_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int EXT_W  = (ADDR_W > FLOW_W) ? ADDR_W : FLOW_W;
   localparam int CMP_W  = 13;

   entry_type mem [FLOWS];

   logic [CSR_W-1:0]     rate_ff, burst_ff;
   logic [LEVEL_W-1:0]   cap_ff;
   logic [ADDR_W-1:0]    clear_cnt_ff;
   logic [ADDR_W-1:0]    flow_ff;
   logic [TIME_W-1:0]    now_ff;
   logic                 new_ff;
   logic                 in_range_ff;
   entry_type            rd_ff;
   logic [LEVEL_W-1:0]   base_level_ff;
   logic [TIME_W-1:0]    base_last_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [PROD_W-1:0]    product_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_allow_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;

   logic [EXT_W-1:0]     req_ext;
   logic [ADDR_W-1:0]    req_addr;
   logic                 fresh;
   logic [TIME_W-1:0]    last_sel;
   logic [TIME_W:0]      diff;
   logic [ELAPSED_W-1:0] elapsed_in;
   logic [SUM_W-1:0]     sum;
   logic [LEVEL_W-1:0]   level_clamped;
   logic                 pass;
   logic [LEVEL_W-1:0]   level_new;
   logic                 res_allow;
   logic [LEVEL_W-1:0]   res_level;
   entry_type            wr_entry;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   entry_type            mem_wdata;

   assign req_ext  = EXT_W'(req_flow_index);
   assign req_addr = req_ext[ADDR_W-1:0];

   // configuration; cap is registered from burst, scaled to 1/1000 packet
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         burst_ff <= BURST_RESET;
         cap_ff   <= CAP_RESET;
      end else begin
         if (csr_write && csr_index == CSR_RATE)  rate_ff  <= csr_wdata;
         if (csr_write && csr_index == CSR_BURST) burst_ff <= csr_wdata;
         cap_ff <= LEVEL_W'(burst_ff) * LEVEL_W'(MILLI_PER_PACKET);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_cnt_ff <= clear_cnt_ff + ADDR_W'(1);
      end
   end

   assign status.clear_last = (clear_cnt_ff == ADDR_W'(FLOWS - 1));
   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;

   // flow table
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = flow_ff;
      mem_wdata = wr_entry;
      if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clear_cnt_ff;
         mem_wdata = '0;
      end else if (cmd.commit && in_range_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.capture) rd_ff <= mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flow_ff     <= req_addr;
         now_ff      <= req_now_ms;
         new_ff      <= req_new_flow;
         in_range_ff <= (CMP_W'(req_flow_index) < CMP_W'(FLOWS));
      end
   end

   // lookup: priming, elapsed time (backward time is zero, long gaps saturate)
   assign fresh    = new_ff || !rd_ff.primed;
   assign last_sel = fresh ? now_ff : rd_ff.last_ms;
   assign diff     = {1'b0, now_ff} - {1'b0, last_sel};

   always_comb begin
      if (diff[TIME_W]) begin
         elapsed_in = '0;
      end else if ((|diff[TIME_W-1:ELAPSED_W]) ||
                   (diff[ELAPSED_W-1] && (|diff[ELAPSED_W-2:0]))) begin
         elapsed_in = ELAPSED_MAX;
      end else begin
         elapsed_in = diff[ELAPSED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         base_level_ff <= fresh ? cap_ff : rd_ff.level;
         base_last_ff  <= last_sel;
         elapsed_ff    <= elapsed_in;
      end
      if (cmd.mult) begin
         product_ff <= elapsed_ff * rate_ff;
      end
   end

   // update: refill, clamp, charge one packet
   assign sum           = SUM_W'(base_level_ff) + SUM_W'(product_ff);
   assign level_clamped = (sum > SUM_W'(cap_ff)) ? cap_ff : sum[LEVEL_W-1:0];
   assign pass          = (level_clamped >= LEVEL_W'(MILLI_PER_PACKET));
   assign level_new     = pass ? (level_clamped - LEVEL_W'(MILLI_PER_PACKET))
                               : level_clamped;

   always_comb begin
      wr_entry.primed = 1'b1;
      if (!in_range_ff) begin
         res_allow        = 1'b0;
         res_level        = '0;
         wr_entry.level   = base_level_ff;
         wr_entry.last_ms = base_last_ff;
      end else if (rate_ff == '0) begin
         res_allow        = 1'b1;
         res_level        = base_level_ff;
         wr_entry.level   = base_level_ff;
         wr_entry.last_ms = base_last_ff;
      end else begin
         res_allow        = pass;
         res_level        = level_new;
         wr_entry.level   = level_new;
         wr_entry.last_ms = now_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_allow_ff <= res_allow;
         rsp_level_ff <= res_level;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_allow      = rsp_allow_ff;
   assign rsp_level_left = rsp_level_ff;

endmodule

// ===== rtl/per_flow_token_bucket.sv =====
// Per-flow token bucket policer. One packet decision per request transaction.
// Request channel: req_valid/req_stall with flow index, time in ms, new-flow flag.
// Response channel: rsp_valid/rsp_stall with allow and remaining level (1/1000 pkt).
// Config port: csr_write/csr_index/csr_wdata; index 0 is rate (pkt/s, 0 = no
// policing), index 1 is burst (pkts). Write only while no request is in flight.
// Each request is captured and then goes through the lookup, multiply and update
// states before its response is registered; req_stall stays high until then, so
// the request path, the 33x20 refill multiply and the single flow table port
// are worked through one request at a time.
// Reset: control state clears and a clearing pass writes every flow table entry
// as unprimed, one entry per cycle; req_stall is high meanwhile.
// Config writes are taken during the clearing pass.
// A held response sits in the output register; the next request can be taken
// meanwhile, and its update waits until the held response is taken.
// Depends on ftb_pkg, ftb_ctrl and ftb_datapath.
module per_flow_token_bucket #(
   parameter int FLOWS = ftb_pkg::FLOWS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [ftb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ftb_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ftb_pkg::FLOW_W-1:0]    req_flow_index,
   input  logic [ftb_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          req_new_flow,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_allow,
   output logic [ftb_pkg::LEVEL_W-1:0]   rsp_level_left
);
   import ftb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ftb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ftb_datapath #(
      .FLOWS (FLOWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_flow_index (req_flow_index),
      .req_now_ms     (req_now_ms),
      .req_new_flow   (req_new_flow),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_allow      (rsp_allow),
      .rsp_level_left (rsp_level_left)
   );

endmodule

// ===== rtl/ftb_checker.sv =====
// ftb_checker: port-level assertions for per_flow_token_bucket, bound to the top.
// Depends on ftb_pkg.
module ftb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_allow,
   input logic [ftb_pkg::LEVEL_W-1:0]   rsp_level_left
);
   import ftb_pkg::*;

   // one request in flight: stall goes up right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // a drop always means less than one packet left
   a_drop_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_allow) |-> (rsp_level_left < LEVEL_W'(MILLI_PER_PACKET)))
      else $error("packet dropped with a full packet of tokens");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_allow) && $stable(rsp_level_left)))
      else $error("response payload changed while stalled");

endmodule

bind per_flow_token_bucket ftb_checker u_ftb_checker (.*);

// ===== verif/tb_per_flow_token_bucket.sv =====
// tb_per_flow_token_bucket: self-checking testbench for the per-flow token bucket policer.
// Runs a directed table and then random phases. Results are checked against a predictor
// held in this file. Depends on ftb_pkg and per_flow_token_bucket.
module tb_per_flow_token_bucket;
   timeunit 1ns;
   timeprecision 1ps;

   import ftb_pkg::*;

   localparam int FLOWS = FLOWS_DEFAULT;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 225;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam logic [63:0] ELAPSED_CAP = 64'h1_0000_0000;

   typedef struct packed {
      logic               allow;
      logic [LEVEL_W-1:0] level;
   } verdict_type;

   typedef enum logic {ROW_PKT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     data;
      logic [FLOW_W-1:0]    flow;
      logic [TIME_W-1:0]    now;
      logic                 fresh;
      bit                   typed;
      verdict_type          known;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FLOW_W-1:0]    req_flow_index = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 req_new_flow = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_allow;
   logic [LEVEL_W-1:0]   rsp_level_left;

   // predictor state and register copies
   logic [CSR_W-1:0]     cfg_rate = RATE_RESET;
   logic [CSR_W-1:0]     cfg_burst = BURST_RESET;
   logic [LEVEL_W-1:0]   flow_level [FLOWS];
   logic [TIME_W-1:0]    flow_last [FLOWS];
   bit                   flow_primed [FLOWS];

   verdict_type  verdict_q [$];
   stim_row_type dir_tab [$];
   int           mismatches = 0;
   bit           quiet = 1'b0;
   bit           hold_off_req = 1'b0;

   always #4 clock = ~clock;

   per_flow_token_bucket #(.FLOWS(FLOWS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_flow_index (req_flow_index),
      .req_now_ms     (req_now_ms),
      .req_new_flow   (req_new_flow),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_allow      (rsp_allow),
      .rsp_level_left (rsp_level_left)
   );

   // lazy refill, clamp to burst, charge one packet
   function automatic verdict_type police_packet(input logic [FLOW_W-1:0] flow,
                                                 input logic [TIME_W-1:0] now,
                                                 input logic fresh);
      logic [63:0] cap;
      logic [63:0] lvl;
      logic [63:0] elapsed;
      verdict_type v;
      cap = 64'(cfg_burst) * 64'd1000;
      if (fresh || !flow_primed[flow]) begin
         flow_level[flow] = cap[LEVEL_W-1:0];
         flow_last[flow] = now;
         flow_primed[flow] = 1'b1;
      end
      if (cfg_rate == '0) begin
         v.allow = 1'b1;
         v.level = flow_level[flow];
         return v;
      end
      elapsed = (now >= flow_last[flow]) ? now - flow_last[flow] : 64'd0;
      if (elapsed > ELAPSED_CAP)
         elapsed = ELAPSED_CAP;
      lvl = 64'(flow_level[flow]) + elapsed * 64'(cfg_rate);
      if (lvl > cap)
         lvl = cap;
      flow_last[flow] = now;
      v.allow = (lvl >= 64'd1000);
      if (v.allow)
         lvl = lvl - 64'd1000;
      flow_level[flow] = lvl[LEVEL_W-1:0];
      v.level = lvl[LEVEL_W-1:0];
      return v;
   endfunction

   function automatic void add_pkt(input logic [FLOW_W-1:0] flow, input logic [TIME_W-1:0] now,
                                   input logic fresh, input bit typed,
                                   input logic allow, input logic [LEVEL_W-1:0] level);
      stim_row_type r;
      r = '{kind: ROW_PKT, idx: '0, data: '0, flow: flow, now: now, fresh: fresh,
            typed: typed, known: '{allow, level}};
      dir_tab.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      stim_row_type r;
      r = '{kind: ROW_CSR, idx: idx, data: data, flow: '0, now: '0, fresh: 1'b0,
            typed: 1'b0, known: '0};
      dir_tab.push_back(r);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == CSR_RATE)
         cfg_rate = data;
      else
         cfg_burst = data;
   endtask

   task automatic send_packet(input logic [FLOW_W-1:0] flow, input logic [TIME_W-1:0] now,
                              input logic fresh, input bit typed, input verdict_type known);
      verdict_type pred;
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_flow_index <= flow;
      req_now_ms <= now;
      req_new_flow <= fresh;
      do @(posedge clock); while (req_stall);
      pred = police_packet(flow, now, fresh);
      verdict_q.push_back(typed ? known : pred);
   endtask

   // stop offering and wait for every outstanding decision
   task automatic drain;
      req_valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
   endtask

   // receiver side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= (!quiet && $urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("response with no transaction pending: allow %0d level_left %0d",
                   rsp_allow, rsp_level_left);
            mismatches++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_allow !== want.allow) begin
               $error("allow: expected %0d, actual %0d", want.allow, rsp_allow);
               mismatches++;
            end
            if (rsp_level_left !== want.level) begin
               $error("level_left: expected %0d, actual %0d", want.level, rsp_level_left);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_per_flow_token_bucket: done, errors");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0]  cur_ms;
      logic [TIME_W-1:0]  now;
      logic [FLOW_W-1:0]  flow;
      logic [FLOW_W-1:0]  hot_base;
      logic [CSR_W-1:0]   p_rate;
      logic [CSR_W-1:0]   p_burst;
      logic               fresh;
      int                 pick;

      foreach (flow_primed[i])
         flow_primed[i] = 1'b0;

      // reset values: rate 1000, burst 2000
      add_pkt(0, 0, 0, 1, 1'b1, 30'd1999000);              // unprimed flow starts full
      add_pkt(0, 0, 0, 0, 0, 0);
      add_pkt(0, 5, 0, 0, 0, 0);                           // refill clamps at burst
      add_pkt(0, 3, 0, 0, 0, 0);                           // time runs backward
      add_pkt(1023, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1'b1, 30'd1999000);
      add_pkt(1023, 0, 0, 0, 0, 0);
      add_pkt(1023, 64'h1_0000_0005, 0, 0, 0, 0);          // elapsed saturates
      add_csr(CSR_RATE, 20'd0);                            // policing off
      add_pkt(2, 100, 1, 1, 1'b1, 30'd2000000);
      add_pkt(0, 7, 0, 0, 0, 0);
      add_csr(CSR_RATE, 20'd1);
      add_csr(CSR_BURST, 20'd1);
      add_pkt(3, 0, 1, 1, 1'b1, 30'd0);
      add_pkt(3, 0, 0, 1, 1'b0, 30'd0);                    // empty bucket drops
      add_pkt(3, 999, 0, 0, 0, 0);
      add_pkt(3, 1000, 0, 0, 0, 0);
      add_pkt(0, 8, 0, 0, 0, 0);                           // stored level above new burst
      add_csr(CSR_BURST, 20'd0);
      add_csr(CSR_RATE, 20'd1000000);
      add_pkt(4, 0, 1, 1, 1'b0, 30'd0);                    // zero capacity
      add_pkt(4, 50, 0, 1, 1'b0, 30'd0);
      add_csr(CSR_RATE, 20'hFFFFF);
      add_csr(CSR_BURST, 20'hFFFFF);
      add_pkt(5, 0, 1, 1, 1'b1, 30'd1048574000);
      add_pkt(5, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
      add_pkt(5, 64'hAAAA_AAAA_5555_5555, 1, 0, 0, 0);
      add_csr(CSR_RATE, 20'd1000000);
      add_csr(CSR_BURST, 20'd1000000);
      add_pkt(6, 1, 0, 1, 1'b1, 30'd999999000);
      add_pkt(6, 1, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            drain();
            write_csr(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            send_packet(dir_tab[i].flow, dir_tab[i].now, dir_tab[i].fresh,
                        dir_tab[i].typed, dir_tab[i].known);
         end
      end

      cur_ms = 64'd1000;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin p_rate = RATE_RESET;     p_burst = BURST_RESET; end
            1: begin p_rate = 20'd0;          p_burst = CSR_W'($urandom_range(1000, 1)); end
            2: begin p_rate = 20'd1;          p_burst = 20'd1; end
            3: begin p_rate = 20'd50;         p_burst = 20'd3; end
            4: begin p_rate = 20'd1000000;    p_burst = 20'd1000000; end
            5: begin p_rate = 20'hFFFFF;      p_burst = 20'hFFFFF; end
            6: begin
               p_rate = CSR_W'($urandom_range(20'hFFFFF, 0));
               p_burst = CSR_W'($urandom_range(20'hFFFFF, 0));
            end
            default: begin p_rate = 20'd300;  p_burst = 20'd0; end
         endcase
         drain();
         write_csr(CSR_RATE, p_rate);
         write_csr(CSR_BURST, p_burst);
         quiet = (ph == 4);
         hot_base = FLOW_W'($urandom_range(FLOWS - 8, 0));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == 20)
               hold_off_req = 1'b1;
            if (ph == 5 && n == 100)
               drain();
            // a few hot flows get back-to-back traffic so buckets run dry
            if ($urandom_range(99) < 70)
               flow = hot_base + FLOW_W'($urandom_range(7, 0));
            else
               flow = FLOW_W'($urandom_range(FLOWS - 1, 0));
            pick = $urandom_range(99);
            if (pick < 60) begin
               cur_ms = cur_ms + 64'($urandom_range(3, 0));
               now = cur_ms;
            end else if (pick < 85) begin
               cur_ms = cur_ms + 64'($urandom_range(2000, 0));
               now = cur_ms;
            end else if (pick < 90) begin
               cur_ms = cur_ms + {31'd0, $urandom, 1'b0};
               now = cur_ms;
            end else if (pick < 95) begin
               now = cur_ms - 64'($urandom_range(50, 0));
            end else begin
               cur_ms = {$urandom, $urandom};
               now = cur_ms;
            end
            fresh = ($urandom_range(99) < 5);
            send_packet(flow, now, fresh, 1'b0, '0);
         end
         quiet = 1'b0;
      end

      drain();
      repeat (12) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("tb_per_flow_token_bucket: done, clean");
      end else begin
         $display("tb_per_flow_token_bucket: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ftb_pkg.sv
rtl/ftb_ctrl.sv
rtl/ftb_datapath.sv
rtl/per_flow_token_bucket.sv
rtl/ftb_checker.sv
verif/tb_per_flow_token_bucket.sv
